/* design/cobs_crc32_deframer_defines.svh */
// Assertion macros for the checker of the deframer.
`ifndef COBS_CRC32_DEFRAMER_DEFINES_SVH
`define COBS_CRC32_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on the block clock, off during reset.
`define CCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the block clock, off during reset.
`define CCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* design/ccd_pkg.sv */
package ccd_pkg;

    // Sizes and constants of the deframer.
    localparam int          MaxFrameDefault = 2048;
    localparam int          PayLenW         = 11;
    localparam int          QueueDepth      = 2;
    localparam int          MinFrameLen     = 4;
    localparam logic [31:0] CrcPoly         = 32'hEDB88320;
    localparam logic [31:0] CrcInit         = 32'hFFFFFFFF;
    localparam logic [7:0]  CodeFullBlock   = 8'hFF;
    localparam logic [7:0]  ByteDelim       = 8'h00;

    // Commands handed from the decoder front to the CRC back end.
    typedef enum logic [1:0] {
        CMD_DATA,
        CMD_END,
        CMD_GARBAGE,
        CMD_OVERFLOW
    } t_cmd_kind;

    // Result kinds as seen on the output port.
    typedef enum logic [2:0] {
        KIND_DATA     = 3'd0,
        KIND_GOOD     = 3'd1,
        KIND_BAD      = 3'd2,
        KIND_GARBAGE  = 3'd3,
        KIND_OVERFLOW = 3'd4,
        KIND_EMPTY    = 3'd5
    } t_out_kind;

    typedef struct packed {
        t_cmd_kind            kind;
        logic [7:0]           data;
        logic [PayLenW-1:0]   pay_len;
        logic                 long_enough;
        logic                 empty;
    } t_cmd;

    // One byte folded into a reflected CRC-32.
    function automatic logic [31:0] crc32_fold(input logic [31:0] crc,
                                               input logic [7:0]  data);
        logic [31:0] c;
        c = crc ^ {24'd0, data};
        for (int k = 0; k < 8; k++) begin
            c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
        end
        return c;
    endfunction

endpackage

/* design/ccd_front.sv */
module ccd_front #(
    parameter int MAX_FRAME = ccd_pkg::MaxFrameDefault
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_rx_valid,
    output logic          o_rx_ready,
    input  logic [7:0]    i_rx_byte,
    output logic          o_cmd_valid,
    input  logic          i_cmd_ready,
    output ccd_pkg::t_cmd o_cmd
);

    localparam int CntW = $clog2(MAX_FRAME);
    localparam int LenW = (CntW > ccd_pkg::PayLenW) ? CntW : ccd_pkg::PayLenW;

    logic [7:0]      r_left, n_left;
    logic            r_pend, n_pend;
    logic [CntW-1:0] r_count, n_count;

    logic            w_accept;
    logic            w_zero;
    logic            w_ovf;
    logic [7:0]      w_left_eff;
    logic            w_pend_eff;
    logic [CntW-1:0] w_cnt_eff;
    logic [LenW-1:0] w_len_ext;

    // A byte is taken whenever the queue has room.
    assign o_rx_ready = i_cmd_ready;
    assign w_accept   = i_rx_valid && i_cmd_ready;
    assign w_zero     = (i_rx_byte == ccd_pkg::ByteDelim);

    // An overflow restarts the frame before the byte is looked at again.
    assign w_ovf      = (r_count == CntW'(MAX_FRAME - 1)) && !w_zero;
    assign w_left_eff = w_ovf ? 8'd0 : r_left;
    assign w_pend_eff = w_ovf ? 1'b0 : r_pend;
    assign w_cnt_eff  = w_ovf ? '0 : r_count;
    assign w_len_ext  = LenW'(w_cnt_eff) - LenW'(ccd_pkg::MinFrameLen);

    // Decoding step: classify the byte and update the block state.
    always_comb begin
        n_left      = r_left;
        n_pend      = r_pend;
        n_count     = r_count;
        o_cmd_valid = 1'b0;
        o_cmd       = '0;
        o_cmd.kind  = ccd_pkg::CMD_DATA;
        if (w_accept) begin
            if (w_left_eff != 8'd0) begin
                if (w_zero) begin
                    // A delimiter inside a block is garbage.
                    n_left      = 8'd0;
                    n_pend      = 1'b0;
                    n_count     = '0;
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = ccd_pkg::CMD_GARBAGE;
                end else begin
                    n_left      = w_left_eff - 8'd1;
                    n_count     = w_cnt_eff + CntW'(1);
                    o_cmd_valid = 1'b1;
                    o_cmd.data  = i_rx_byte;
                end
            end else if (w_zero) begin
                // Frame end: the back end judges the CRC.
                n_left            = 8'd0;
                n_pend            = 1'b0;
                n_count           = '0;
                o_cmd_valid       = 1'b1;
                o_cmd.kind        = ccd_pkg::CMD_END;
                o_cmd.empty       = (w_cnt_eff == '0) && !w_pend_eff;
                o_cmd.long_enough = (w_cnt_eff >= CntW'(ccd_pkg::MinFrameLen));
                o_cmd.pay_len     = w_len_ext[ccd_pkg::PayLenW-1:0];
            end else begin
                // A code byte opens a new block.
                n_left  = i_rx_byte - 8'd1;
                n_pend  = (i_rx_byte != ccd_pkg::CodeFullBlock);
                n_count = w_cnt_eff;
                if (w_ovf) begin
                    o_cmd_valid = 1'b1;
                    o_cmd.kind  = ccd_pkg::CMD_OVERFLOW;
                end else if (w_pend_eff) begin
                    // The zero implied between blocks.
                    n_count     = w_cnt_eff + CntW'(1);
                    o_cmd_valid = 1'b1;
                end
            end
        end
    end

    // Block state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left  <= 8'd0;
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            r_left  <= n_left;
            r_pend  <= n_pend;
            r_count <= n_count;
        end
    end

endmodule

/* design/ccd_queue.sv */
module ccd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ccd_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ccd_pkg::t_cmd o_pop_cmd
);

    localparam int Depth = ccd_pkg::QueueDepth;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    ccd_pkg::t_cmd   r_mem [Depth];
    logic [PtrW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PtrW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CntW-1:0] r_count, n_count;
    logic            w_push;
    logic            w_pop;

    assign o_push_ready = (r_count != CntW'(Depth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PtrW'(Depth - 1)) ? '0 : r_wr_ptr + PtrW'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PtrW'(Depth - 1)) ? '0 : r_rd_ptr + PtrW'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + CntW'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - CntW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

/* design/ccd_back.sv */
module ccd_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    output logic                         o_cmd_ready,
    input  ccd_pkg::t_cmd                i_cmd,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_out_kind,
    output logic [7:0]                   o_out_byte,
    output logic [ccd_pkg::PayLenW-1:0]  o_payload_len,
    output logic                         o_end_of_frame
);

    logic                         r_out_valid;
    logic [31:0]                  r_crc, n_crc;
    ccd_pkg::t_out_kind           r_kind, n_kind;
    logic [7:0]                   r_byte, n_byte;
    logic [ccd_pkg::PayLenW-1:0]  r_len, n_len;
    logic                         r_eof, n_eof;
    logic                         w_pop;

    // The output register takes a new command when empty or being drained.
    assign o_cmd_ready = !r_out_valid || i_out_ready;
    assign w_pop       = i_cmd_valid && o_cmd_ready;

    // CRC fold on data and a CRC restart on every other command; frame verdict on the delimiter.
    always_comb begin
        n_crc  = ccd_pkg::CrcInit;
        n_kind = ccd_pkg::KIND_DATA;
        n_byte = 8'd0;
        n_len  = '0;
        n_eof  = 1'b1;
        case (i_cmd.kind)
            ccd_pkg::CMD_DATA: begin
                n_crc  = ccd_pkg::crc32_fold(r_crc, i_cmd.data);
                n_byte = i_cmd.data;
                n_eof  = 1'b0;
            end
            ccd_pkg::CMD_END: begin
                if (i_cmd.empty) begin
                    n_kind = ccd_pkg::KIND_EMPTY;
                end else if (i_cmd.long_enough && (r_crc == 32'd0)) begin
                    n_kind = ccd_pkg::KIND_GOOD;
                    n_len  = i_cmd.pay_len;
                end else begin
                    n_kind = ccd_pkg::KIND_BAD;
                end
            end
            ccd_pkg::CMD_GARBAGE: begin
                n_kind = ccd_pkg::KIND_GARBAGE;
            end
            default: begin
                n_kind = ccd_pkg::KIND_OVERFLOW;
            end
        endcase
    end

    // Control state and running CRC.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_crc       <= ccd_pkg::CrcInit;
        end else begin
            if (o_cmd_ready) begin
                r_out_valid <= i_cmd_valid;
            end
            if (w_pop) begin
                r_crc <= n_crc;
            end
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_len  <= n_len;
            r_eof  <= n_eof;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_kind     = r_kind;
    assign o_out_byte     = r_byte;
    assign o_payload_len  = r_len;
    assign o_end_of_frame = r_eof;

endmodule

/* design/cobs_crc32_deframer.sv */
// COBS deframer with CRC-32 check.
// Input channel: i_rx_valid / o_rx_ready carry one received byte, i_rx_byte.
// Output channel: o_out_valid / i_out_ready carry one result: o_out_kind,
// o_out_byte, o_payload_len and o_end_of_frame.
// Each decoded byte, the implied zero between blocks included, goes out as a
// data result; a frame delimiter or an abort gives one status result.
// Code bytes that open a block with no implied zero give no result.
// Each result passes through the queue and then the output register.
// Throughput: one byte per cycle while the receiver takes results; the
// decoder front writes a two-entry queue, and the back end folds one byte
// per cycle into the CRC and loads the output register.
// Reset clears the block state, the queue and the output register; the CRC
// returns to all ones and the next byte starts a new frame.
// When the receiver stalls, the output register holds its result, the queue
// fills, and o_rx_ready falls once it is full.
module cobs_crc32_deframer #(
    parameter int MAX_FRAME = ccd_pkg::MaxFrameDefault
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_rx_valid,
    output logic                         o_rx_ready,
    input  logic [7:0]                   i_rx_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [2:0]                   o_out_kind,
    output logic [7:0]                   o_out_byte,
    output logic [ccd_pkg::PayLenW-1:0]  o_payload_len,
    output logic                         o_end_of_frame
);

    logic          w_push_valid;
    logic          w_push_ready;
    ccd_pkg::t_cmd w_push_cmd;
    logic          w_pop_valid;
    logic          w_pop_ready;
    ccd_pkg::t_cmd w_pop_cmd;

    // Decoder front: COBS state and command generation.
    ccd_front #(
        .MAX_FRAME (MAX_FRAME)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_cmd_valid (w_push_valid),
        .i_cmd_ready (w_push_ready),
        .o_cmd       (w_push_cmd)
    );

    // Command queue between front and back.
    ccd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    // Back end: CRC, frame verdict and output register.
    ccd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (w_pop_valid),
        .o_cmd_ready    (w_pop_ready),
        .i_cmd          (w_pop_cmd),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_payload_len  (o_payload_len),
        .o_end_of_frame (o_end_of_frame)
    );

endmodule

/* design/ccd_checker.sv */
`include "cobs_crc32_deframer_defines.svh"

module ccd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_rx_valid,
    input logic                         o_rx_ready,
    input logic [7:0]                   i_rx_byte,
    input logic                         o_out_valid,
    input logic                         i_out_ready,
    input logic [2:0]                   o_out_kind,
    input logic [7:0]                   o_out_byte,
    input logic [ccd_pkg::PayLenW-1:0]  o_payload_len,
    input logic                         o_end_of_frame
);

    logic w_is_data;
    logic w_is_good;

    assign w_is_data = (o_out_kind == 3'(ccd_pkg::KIND_DATA));
    assign w_is_good = (o_out_kind == 3'(ccd_pkg::KIND_GOOD));

    // Data results never close a frame; status results always do.
    `CCD_ASSERT_NOW(a_eof_matches_kind, o_out_valid, o_end_of_frame == !w_is_data, "end_of_frame disagrees with kind")

    // Status results carry no byte.
    `CCD_ASSERT_NOW(a_status_byte_zero, o_out_valid && !w_is_data, o_out_byte == 8'd0, "status result with nonzero byte")

    // Only a good frame reports a length.
    `CCD_ASSERT_NOW(a_len_only_good, o_out_valid && !w_is_good, o_payload_len == '0, "length on a result that is not a good frame")

    // A stalled result holds.
    `CCD_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_kind) && $stable(o_out_byte), "stalled result changed")

    // An offered byte stays on the port until its transfer.
    `CCD_ASSERT_NEXT(a_rx_hold, i_rx_valid && !o_rx_ready, i_rx_valid && $stable(i_rx_byte), "offered byte changed before transfer")

endmodule

bind cobs_crc32_deframer ccd_checker u_ccd_checker (.*);
